// ===== hw/rtl/restoring_divider_unit_macros.svh =====
// Assertion macros for the restoring divider unit.
// Used only by the top level; no other dependencies.
`ifndef RESTORING_DIVIDER_UNIT_MACROS_SVH
`define RESTORING_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RDU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdu assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdu assertion failed");

`endif

// ===== hw/rtl/rdu_pkg.sv =====
// Shared constants and types for the restoring divider unit.
// No dependencies.
package rdu_pkg;

	localparam int unsigned RDU_WIDTH = 32;

	// controller -> datapath commands
	typedef struct packed {
		logic load;  // capture operands, clear partial remainder
		logic step;  // one shift/subtract/restore step
		logic move;  // copy result into output register
	} rdu_cmd_t;

endpackage

// ===== hw/rtl/rdu_if.sv =====
// Valid/ready channel interfaces for operands and results.
// Depends on rdu_pkg.
interface rdu_req_if import rdu_pkg::*; #(
	parameter int unsigned WIDTH = RDU_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] dividend_value;
	logic [WIDTH-1:0] divisor_value;

	modport source (output valid, output dividend_value, output divisor_value, input ready);
	modport sink   (input valid, input dividend_value, input divisor_value, output ready);
endinterface

interface rdu_rsp_if import rdu_pkg::*; #(
	parameter int unsigned WIDTH = RDU_WIDTH
) ();
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] quotient_value;
	logic [WIDTH-1:0] remainder_value;

	modport source (output valid, output quotient_value, output remainder_value, input ready);
	modport sink   (input valid, input quotient_value, input remainder_value, output ready);
endinterface

// ===== hw/rtl/rdu_ctrl.sv =====
// Sequencer for the restoring divider: step counter, handshakes, output valid.
// Depends on rdu_pkg.
module rdu_ctrl import rdu_pkg::*; #(
	parameter int unsigned WIDTH = RDU_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rdu_cmd_t cmd
);

	localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// a new transaction may enter in the same cycle the finished result moves out
	always_comb begin
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: in_ready = out_free;
			default:   in_ready = 1'b0;
		endcase
	end

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.step = (state_q == ST_BUSY);
		cmd.move = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.load) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end else if (cmd.move) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rdu_dpath.sv =====
// Datapath for the restoring divider: partial remainder, quotient shifter,
// one subtract/restore per step, output register. Depends on rdu_pkg.
module rdu_dpath import rdu_pkg::*; #(
	parameter int unsigned WIDTH = RDU_WIDTH
) (
	input  logic             clk,
	input  rdu_cmd_t         cmd,
	input  logic [WIDTH-1:0] dividend_value,
	input  logic [WIDTH-1:0] divisor_value,
	output logic [WIDTH-1:0] quotient_value,
	output logic [WIDTH-1:0] remainder_value
);

	// the top bit of the partial remainder drops out on every shift, so only
	// WIDTH bits are held between steps
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] div_q;
	logic [WIDTH-1:0] quo_out_q;
	logic [WIDTH-1:0] rem_out_q;

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= dividend_value;
			div_q <= divisor_value;
		end else if (cmd.step) begin
			// sign set: keep the shifted remainder (restore), quotient bit 0
			if (diff[WIDTH]) begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end else begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end
		end
		if (cmd.move) begin
			quo_out_q <= quo_q;
			rem_out_q <= rem_q;
		end
	end

	assign quotient_value  = quo_out_q;
	assign remainder_value = rem_out_q;

endmodule

// ===== hw/rtl/restoring_divider_unit.sv =====
// Unsigned restoring divider, top level.
// Depends on rdu_pkg, rdu_if, rdu_ctrl, rdu_dpath and the macros header.
//
// Usage:
//   req carries dividend_value and divisor_value; rsp returns quotient_value
//   and remainder_value. Both are valid/ready channels; a transaction moves at
//   a rising edge with valid and ready high.
//   One operand pair is worked at a time. After the accepting edge the
//   datapath runs WIDTH shift/subtract steps, one quotient bit per cycle, then
//   moves the result into the output register once that register is free.
//   The single subtract/restore step is reused for all WIDTH steps, so a new
//   pair is not accepted until the current division has finished.
//   The next pair is accepted in the same cycle a result moves out, so the
//   output register lets the next division run while a result waits.
//   If rsp stalls, a finished result waits in the output register; a further
//   finished result then holds in the datapath and req stays not ready.
//   A zero divisor gives an all-ones quotient and remainder = dividend.
//   Reset (arst_n low) empties the output and returns to idle, ready at once.
`include "restoring_divider_unit_macros.svh"

module restoring_divider_unit import rdu_pkg::*; #(
	parameter int unsigned WIDTH = RDU_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rdu_req_if.sink   req,
	rdu_rsp_if.source rsp
);

	rdu_cmd_t cmd;

	rdu_ctrl #(
		.WIDTH (WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	rdu_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk             (clk),
		.cmd             (cmd),
		.dividend_value  (req.dividend_value),
		.divisor_value   (req.divisor_value),
		.quotient_value  (rsp.quotient_value),
		.remainder_value (rsp.remainder_value)
	);

	`RDU_ASSERT_SAME(a_load_not_step, clk, arst_n, cmd.load, !cmd.step)
	`RDU_ASSERT_NEXT(a_load_starts_steps, clk, arst_n, cmd.load, cmd.step && !cmd.move)
	`RDU_ASSERT_NEXT(a_move_sets_valid, clk, arst_n, cmd.move, rsp.valid)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for restoring_divider_unit: directed and random operand pairs
// checked against an in-bench restoring-division predictor.
// Depends on rdu_pkg, rdu_req_if / rdu_rsp_if and the divider RTL.
module testbench import rdu_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WIDTH       = RDU_WIDTH;
	localparam int unsigned LATENCY     = WIDTH + 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_PCT    = 37;

	typedef logic [WIDTH-1:0] word_t;

	typedef struct {
		word_t quotient;
		word_t remainder;
	} quot_rem_t;

	logic clk;
	logic arst_n;

	rdu_req_if #(.WIDTH(WIDTH)) req_ch ();
	rdu_rsp_if #(.WIDTH(WIDTH)) rsp_ch ();

	restoring_divider_unit #(.WIDTH(WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	quot_rem_t expected_results[$];
	int unsigned error_count = 0;
	bit steady_flow = 1'b0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.dividend_value = '0;
		req_ch.divisor_value = '0;
		rsp_ch.ready = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// one quotient bit per step; restore when the trial subtraction goes negative
	function automatic quot_rem_t restoring_divide(input word_t dividend, input word_t divisor);
		logic [WIDTH:0] part_rem;
		word_t quo;
		quot_rem_t res;
		part_rem = '0;
		quo = dividend;
		for (int i = 0; i < WIDTH; i++) begin
			part_rem = {part_rem[WIDTH-1:0], quo[WIDTH-1]};
			quo = quo << 1;
			part_rem = part_rem - {1'b0, divisor};
			if (part_rem[WIDTH]) begin
				part_rem = part_rem + {1'b0, divisor};
			end else begin
				quo[0] = 1'b1;
			end
		end
		res.quotient = quo;
		res.remainder = part_rem[WIDTH-1:0];
		return res;
	endfunction

	// result sink: random back-pressure (none while steady_flow is set), driven on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		quot_rem_t exp_res;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: quotient_value=%h remainder_value=%h",
					rsp_ch.quotient_value, rsp_ch.remainder_value);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (rsp_ch.quotient_value !== exp_res.quotient) begin
					$error("quotient_value mismatch: expected %h actual %h",
						exp_res.quotient, rsp_ch.quotient_value);
					error_count++;
				end
				if (rsp_ch.remainder_value !== exp_res.remainder) begin
					$error("remainder_value mismatch: expected %h actual %h",
						exp_res.remainder, rsp_ch.remainder_value);
					error_count++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_pair(input word_t dividend, input word_t divisor);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.dividend_value <= dividend;
		req_ch.divisor_value <= divisor;
		do @(posedge clk); while (!req_ch.ready);
		expected_results.push_back(restoring_divide(dividend, divisor));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	task automatic test_operand_extremes();
		send_pair('0, 32'd1);
		send_pair('1, 32'd1);
		send_pair('1, '1);
		send_pair('0, '1);
		send_pair(32'd1, '1);
		send_pair(32'h8000_0000, 32'd2);
		send_pair('1, 32'h8000_0000);
		send_pair(32'h7fff_ffff, 32'h8000_0000);
		send_pair(32'd5, 32'd3);
		send_pair(32'd7, 32'd7);
		send_pair(32'd6, 32'd7);
		send_pair(32'haaaa_aaaa, 32'h5555_5555);
		send_pair(32'h5555_5555, 32'haaaa_aaaa);
		send_pair(32'hffff_fffe, 32'hffff_ffff);
		send_pair(32'hdead_beef, 32'h0000_1234);
		wait_drain();
	endtask

	// divide by zero: all-ones quotient, remainder passes the dividend through
	task automatic test_zero_divisor();
		send_pair('0, '0);
		send_pair(32'd1, '0);
		send_pair('1, '0);
		send_pair(32'h1234_5678, '0);
		send_pair(32'h8000_0000, '0);
		wait_drain();
	endtask

	// four rounds of three transactions, each followed by a wait until the pipe empties and a random pause
	task automatic test_drain_pause();
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 3; j++) begin
				send_pair($urandom, $urandom >> $urandom_range(WIDTH - 1));
			end
			wait_drain();
			repeat ($urandom_range(LATENCY)) @(negedge clk);
		end
	endtask

	task automatic test_random_pairs(input int unsigned count);
		word_t dividend;
		word_t divisor;
		for (int unsigned n = 0; n < count; n++) begin
			steady_flow = (n >= count / 3) && (n < count / 3 + 200);
			dividend = $urandom;
			divisor = $urandom;
			case ($urandom_range(9))
				4: divisor = $urandom_range(15);
				5: divisor = divisor >> $urandom_range(WIDTH - 1);
				6: divisor = ($urandom_range(3) == 0) ? '0 : dividend - $urandom_range(3);
				7: dividend = dividend >> $urandom_range(WIDTH - 1);
				8: divisor = dividend + $urandom_range(2) - 1;
				9: begin
					divisor = $urandom >> $urandom_range(16, WIDTH - 1);
					dividend = divisor * $urandom_range(1000) + $urandom_range(3);
				end
				default: ;
			endcase
			send_pair(dividend, divisor);
		end
		steady_flow = 1'b0;
		wait_drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_operand_extremes();
		test_zero_divisor();
		test_drain_pause();
		test_random_pairs(1500);
		repeat (2 * LATENCY) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
